// ===== hdl/eslt_pkg.sv =====
package eslt_pkg;

  // source count and widths
  localparam int NSRC        = 10;
  localparam int SRC_W       = 4;
  localparam int TIMER_WIDTH = 16;
  localparam int CNT_W       = 8;
  localparam int STAT_W      = 16;
  localparam int CODE_W      = 4;
  localparam int CMD_W       = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // marker for codes that map to no source
  localparam logic [SRC_W-1:0] SRC_NONE = 4'd15;

  // fixed source slots with their own count and interval registers
  localparam logic [SRC_W-1:0] SRC_MEMORY = 4'd0;
  localparam logic [SRC_W-1:0] SRC_QUEUE  = 4'd1;

  // remaining source slots, count of one and no holdoff
  localparam logic [SRC_W-1:0] SRC_I2C     = 4'd2;
  localparam logic [SRC_W-1:0] SRC_RTC     = 4'd3;
  localparam logic [SRC_W-1:0] SRC_EXP1    = 4'd4;
  localparam logic [SRC_W-1:0] SRC_EXP2    = 4'd5;
  localparam logic [SRC_W-1:0] SRC_EXP3    = 4'd6;
  localparam logic [SRC_W-1:0] SRC_WDOG    = 4'd7;
  localparam logic [SRC_W-1:0] SRC_DEBUG   = 4'd8;
  localparam logic [SRC_W-1:0] SRC_UNKNOWN = 4'd9;

  // error codes as carried on the input stream
  localparam logic [CODE_W-1:0] EC_NONE    = 4'd0;
  localparam logic [CODE_W-1:0] EC_I2C     = 4'd1;
  localparam logic [CODE_W-1:0] EC_I2C_TMO = 4'd2;
  localparam logic [CODE_W-1:0] EC_QUEUE   = 4'd3;
  localparam logic [CODE_W-1:0] EC_MEM     = 4'd4;
  localparam logic [CODE_W-1:0] EC_RTC     = 4'd5;
  localparam logic [CODE_W-1:0] EC_EXP1    = 4'd6;
  localparam logic [CODE_W-1:0] EC_EXP2    = 4'd7;
  localparam logic [CODE_W-1:0] EC_EXP3    = 4'd8;
  localparam logic [CODE_W-1:0] EC_WDOG    = 4'd9;
  localparam logic [CODE_W-1:0] EC_DBG     = 4'd10;
  localparam logic [CODE_W-1:0] EC_UNK     = 4'd11;
  localparam logic [CODE_W-1:0] EC_TOP     = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_REPORT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_QUEUE_COUNT     = 3'd0,
    REG_QUEUE_INTERVAL  = 3'd1,
    REG_MEMORY_COUNT    = 3'd2,
    REG_MEMORY_INTERVAL = 3'd3,
    REG_READ_CLEAR_MASK = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [CNT_W-1:0]      RST_LOG_COUNT    = 8'd25;
  localparam logic [STAT_W-1:0]     RST_LOG_INTERVAL = 16'd15;
  localparam logic [CFG_DATA_W-1:0] RST_CLEAR_MASK   = 16'h807E;

  // status word bit of each source
  function automatic logic [STAT_W-1:0] src_bit(input logic [SRC_W-1:0] s);
    logic [STAT_W-1:0] b;
    case (s)
      SRC_MEMORY:  b = 16'h0001;
      SRC_QUEUE:   b = 16'h0002;
      SRC_I2C:     b = 16'h0004;
      SRC_RTC:     b = 16'h0008;
      SRC_EXP1:    b = 16'h0010;
      SRC_EXP2:    b = 16'h0020;
      SRC_EXP3:    b = 16'h0040;
      SRC_WDOG:    b = 16'h0080;
      SRC_DEBUG:   b = 16'h4000;
      SRC_UNKNOWN: b = 16'h8000;
      default:     b = '0;
    endcase
    return b;
  endfunction

  // error code to source slot; both i2c codes share one slot
  function automatic logic [SRC_W-1:0] code_src(input logic [CODE_W-1:0] c);
    logic [SRC_W-1:0] s;
    case (c)
      EC_I2C, EC_I2C_TMO: s = SRC_I2C;
      EC_QUEUE:           s = SRC_QUEUE;
      EC_MEM:             s = SRC_MEMORY;
      EC_RTC:             s = SRC_RTC;
      EC_EXP1:            s = SRC_EXP1;
      EC_EXP2:            s = SRC_EXP2;
      EC_EXP3:            s = SRC_EXP3;
      EC_WDOG:            s = SRC_WDOG;
      EC_DBG:             s = SRC_DEBUG;
      EC_UNK:             s = SRC_UNKNOWN;
      default:            s = SRC_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/error_status_log_throttle_unit.sv =====
// Error log throttle for ten error sources. Each beat on the input stream is one
// command: report an error code, advance the holdoff timers by one tick, or read
// and clear the sticky status flags. Every command yields exactly one result beat
// carrying log_now, the status word (read only) and the prior flag of the named
// source. A command's result is computed straight from the per-source flag,
// counter and timer registers and lands in the output register on the accepting
// edge, so one beat per cycle flows as long as the output side is ready; the only
// holdup is a full output register that is not being drained. Configuration
// writes should be made only while no beat is in flight.
module error_status_log_throttle_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [eslt_pkg::IN_TDATA_W-1:0] in_tdata,   // command[1:0], error_code[5:2]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [eslt_pkg::OUT_TDATA_W-1:0] out_tdata, // log_now[0], status_bits[16:1],
                                                      // selected_flag[17]
  // configuration
  input  logic                            cfg_we,
  input  logic [eslt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [eslt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import eslt_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]       queue_count_r, memory_count_r;
  logic [TIMER_WIDTH-1:0] queue_interval_r, memory_interval_r;
  logic [STAT_W-1:0]      clear_mask_r;

  // per-source state
  logic [NSRC-1:0]        flags_r, flags_nxt;
  logic [CNT_W-1:0]       cnt_r [NSRC];
  logic [CNT_W-1:0]       cnt_nxt [NSRC];
  logic [TIMER_WIDTH-1:0] tmr_r [NSRC];
  logic [TIMER_WIDTH-1:0] tmr_nxt [NSRC];

  // output register
  logic                   out_valid_r;
  logic                   log_now_r, log_now_nxt;
  logic [STAT_W-1:0]      status_r, status_nxt;
  logic                   sel_r, sel_nxt;

  logic                   in_fire;
  cmd_t                   cmd;
  logic [CODE_W-1:0]      code;
  logic [SRC_W-1:0]       src;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tdata[CMD_W-1:0]);
  assign code      = in_tdata[CMD_W +: CODE_W];
  assign src       = code_src(code);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_count_r     <= RST_LOG_COUNT;
      queue_interval_r  <= TIMER_WIDTH'(RST_LOG_INTERVAL);
      memory_count_r    <= RST_LOG_COUNT;
      memory_interval_r <= TIMER_WIDTH'(RST_LOG_INTERVAL);
      clear_mask_r      <= RST_CLEAR_MASK;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_QUEUE_COUNT:     queue_count_r     <= cfg_wdata[CNT_W-1:0];
        REG_QUEUE_INTERVAL:  queue_interval_r  <= cfg_wdata[TIMER_WIDTH-1:0];
        REG_MEMORY_COUNT:    memory_count_r    <= cfg_wdata[CNT_W-1:0];
        REG_MEMORY_INTERVAL: memory_interval_r <= cfg_wdata[TIMER_WIDTH-1:0];
        REG_READ_CLEAR_MASK: clear_mask_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-source update and result for one command
  always_comb begin
    logic [SRC_W-1:0]       si;
    logic [CNT_W-1:0]       lim;
    logic [TIMER_WIDTH-1:0] ivl;
    logic [CNT_W:0]         inc;
    flags_nxt   = flags_r;
    log_now_nxt = 1'b0;
    status_nxt  = '0;
    sel_nxt     = 1'b0;
    for (int i = 0; i < NSRC; i++) begin
      si  = SRC_W'(i);
      cnt_nxt[i] = cnt_r[i];
      tmr_nxt[i] = tmr_r[i];
      lim = (si == SRC_MEMORY) ? memory_count_r :
            (si == SRC_QUEUE)  ? queue_count_r  : CNT_W'(1);
      ivl = (si == SRC_MEMORY) ? memory_interval_r :
            (si == SRC_QUEUE)  ? queue_interval_r  : '0;
      inc = {1'b0, cnt_r[i]} + (CNT_W+1)'(1);
      if (src == si) sel_nxt = flags_r[i];
      case (cmd)
        CMD_REPORT: begin
          if (src == si) begin
            flags_nxt[i] = 1'b1;
            if (cnt_r[i] == '0 && tmr_r[i] == '0) begin
              log_now_nxt = 1'b1;
              tmr_nxt[i]  = ivl;
            end
            cnt_nxt[i] = (inc >= {1'b0, lim}) ? '0 : inc[CNT_W-1:0];
          end
        end
        CMD_TICK: begin
          if (tmr_r[i] != '0) tmr_nxt[i] = tmr_r[i] - TIMER_WIDTH'(1);
        end
        CMD_READ: begin
          if (flags_r[i]) status_nxt = status_nxt | src_bit(si);
          if ((clear_mask_r & src_bit(si)) != '0) flags_nxt[i] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      for (int i = 0; i < NSRC; i++) begin
        cnt_r[i] <= '0;
        tmr_r[i] <= '0;
      end
    end else if (in_fire) begin
      flags_r <= flags_nxt;
      for (int i = 0; i < NSRC; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        tmr_r[i] <= tmr_nxt[i];
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      log_now_r <= log_now_nxt;
      status_r  <= status_nxt;
      sel_r     <= sel_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-STAT_W-2){1'b0}}, sel_r, status_r, log_now_r};

  // a result never carries both a log strobe and a status word
  a_log_excl_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && log_now_r |-> status_r == '0)
    else $error("log strobe and status word in one result");

  // an accepted report of a memory error leaves its flag set
  a_mem_flag_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_REPORT && src == SRC_MEMORY |=> flags_r[0])
    else $error("memory flag not set after report");

  // a logged report of the memory source reloads its timer
  a_mem_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_REPORT && src == SRC_MEMORY && log_now_nxt
    |=> tmr_r[0] == $past(memory_interval_r))
    else $error("memory timer not reloaded on log");

  // state only moves on an accepted command
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(flags_r))
    else $error("flags changed without a command");

  // a result waiting on a stalled output blocks new commands
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

endmodule

// ===== test/tb_error_status_log_throttle_unit.sv =====
module tb_error_status_log_throttle_unit;
  import eslt_pkg::*;

  // register index that maps to nothing
  localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_IDX = 3'd5;

  localparam int NO_SLOT     = -1;
  localparam int I2C_SLOT    = 2;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 204;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 10000;

  // status word bit per source slot, slot 0 in the low entry
  localparam logic [NSRC-1:0][STAT_W-1:0] FLAG_BITS = {
    16'h8000, 16'h4000, 16'h0080, 16'h0040, 16'h0020,
    16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001
  };

  typedef struct packed {
    cmd_t              op;
    logic [CODE_W-1:0] code;
  } err_cmd_t;

  typedef struct packed {
    logic              log_now;
    logic [STAT_W-1:0] status_bits;
    logic              selected_flag;
  } throttle_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  error_status_log_throttle_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // throttle state mirrored in the testbench
  logic              sticky_flag [NSRC];
  logic [CNT_W-1:0]  occ_count   [NSRC];
  logic [STAT_W-1:0] holdoff     [NSRC];
  logic [CNT_W-1:0]  queue_count    = RST_LOG_COUNT;
  logic [STAT_W-1:0] queue_interval = RST_LOG_INTERVAL;
  logic [CNT_W-1:0]  mem_count      = RST_LOG_COUNT;
  logic [STAT_W-1:0] mem_interval   = RST_LOG_INTERVAL;
  logic [STAT_W-1:0] clear_mask     = RST_CLEAR_MASK;

  err_cmd_t      cmd_backlog [$];
  throttle_res_t expected_res [$];
  err_cmd_t      cmd_on_bus;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int beat_count = 0;
  int issued_count = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < NSRC; i++) begin
      sticky_flag[i] = 1'b0;
      occ_count[i] = '0;
      holdoff[i] = '0;
    end
  end

  // expected result of one command, advancing the mirrored state
  function automatic throttle_res_t throttle_step(cmd_t op, logic [CODE_W-1:0] code);
    throttle_res_t r;
    int slot;
    int wrap_at;
    logic [STAT_W-1:0] reload;
    logic [CNT_W:0] nxt;
    r = '0;
    case (code)
      EC_I2C, EC_I2C_TMO: slot = I2C_SLOT;
      EC_QUEUE: slot = int'(SRC_QUEUE);
      EC_MEM:   slot = int'(SRC_MEMORY);
      EC_RTC, EC_EXP1, EC_EXP2, EC_EXP3, EC_WDOG, EC_DBG, EC_UNK:
        slot = int'(code) - 2;
      default: slot = NO_SLOT;
    endcase
    if (slot != NO_SLOT) r.selected_flag = sticky_flag[slot];
    case (op)
      CMD_REPORT: begin
        if (slot != NO_SLOT) begin
          // per-source count and interval; all other sources log every time
          wrap_at = 1;
          reload = '0;
          if (slot == int'(SRC_MEMORY)) begin
            wrap_at = int'(mem_count);
            reload = mem_interval;
          end else if (slot == int'(SRC_QUEUE)) begin
            wrap_at = int'(queue_count);
            reload = queue_interval;
          end
          sticky_flag[slot] = 1'b1;
          if (occ_count[slot] == 0 && holdoff[slot] == 0) begin
            r.log_now = 1'b1;
            holdoff[slot] = reload;
          end
          // count of zero wraps immediately, same as one
          nxt = occ_count[slot] + 1'b1;
          occ_count[slot] = (int'(nxt) >= wrap_at) ? '0 : nxt[CNT_W-1:0];
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < NSRC; i++)
          if (holdoff[i] != 0) holdoff[i] = holdoff[i] - 1'b1;
      end
      CMD_READ: begin
        for (int i = 0; i < NSRC; i++) begin
          if (sticky_flag[i]) r.status_bits = r.status_bits | FLAG_BITS[i];
          if ((clear_mask & FLAG_BITS[i]) != 0) sticky_flag[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // input driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin : drv
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_res.push_back(throttle_step(cmd_on_bus.op, cmd_on_bus.code));
      if (!in_tvalid || in_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cmd_on_bus.code, cmd_on_bus.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : mon
    throttle_res_t want;
    throttle_res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.log_now = out_tdata[0];
        got.status_bits = out_tdata[16:1];
        got.selected_flag = out_tdata[17];
        if (expected_res.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d arrived with nothing pending: %h", beat_count, out_tdata);
        end else begin
          want = expected_res.pop_front();
          if (got.log_now !== want.log_now || got.status_bits !== want.status_bits ||
              got.selected_flag !== want.selected_flag) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"beat %0d: log_now %0b/%0b status_bits %h/%h ",
                        "selected_flag %0b/%0b (exp/got)"},
                       beat_count, want.log_now, got.log_now, want.status_bits,
                       got.status_bits, want.selected_flag, got.selected_flag);
          end
        end
        beat_count++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_t op, input logic [CODE_W-1:0] code);
    err_cmd_t c;
    c.op = op;
    c.code = code;
    cmd_backlog.push_back(c);
    issued_count++;
  endtask

  // hold off until every command is taken and every result has come back
  task automatic drain();
    while (beat_count < issued_count)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_QUEUE_COUNT:     queue_count = data[CNT_W-1:0];
      REG_QUEUE_INTERVAL:  queue_interval = data;
      REG_MEMORY_COUNT:    mem_count = data[CNT_W-1:0];
      REG_MEMORY_INTERVAL: mem_interval = data;
      REG_READ_CLEAR_MASK: clear_mask = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int roll;
    cmd_t op;
    logic [CODE_W-1:0] code;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 82;

    // directed: every code reported at reset settings, then the other commands
    for (int c = 0; c <= int'(EC_TOP); c++) push_cmd(CMD_REPORT, CODE_W'(c));
    push_cmd(CMD_REPORT, EC_MEM);
    push_cmd(CMD_NOP, EC_QUEUE);
    push_cmd(CMD_NOP, EC_NONE);
    push_cmd(CMD_TICK, EC_TOP);
    push_cmd(CMD_READ, EC_I2C);
    push_cmd(CMD_READ, EC_MEM);
    push_cmd(CMD_REPORT, EC_I2C_TMO);
    drain();

    for (int phase = 1; phase <= PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 25;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // register settings per phase, extremes first
      case (phase)
        1: begin
          write_reg(REG_QUEUE_COUNT, 16'd1);
          write_reg(REG_QUEUE_INTERVAL, 16'd0);
          write_reg(REG_MEMORY_COUNT, 16'd1);
          write_reg(REG_MEMORY_INTERVAL, 16'd0);
          write_reg(REG_READ_CLEAR_MASK, 16'hFFFF);
        end
        2: begin
          write_reg(REG_QUEUE_COUNT, 16'd255);
          write_reg(REG_QUEUE_INTERVAL, 16'hFFFF);
          write_reg(REG_MEMORY_COUNT, 16'd255);
          write_reg(REG_MEMORY_INTERVAL, 16'hFFFF);
          write_reg(REG_READ_CLEAR_MASK, 16'h0000);
        end
        3: begin
          // counts of zero with junk in the upper byte
          write_reg(REG_QUEUE_COUNT, 16'hFF00);
          write_reg(REG_QUEUE_INTERVAL, 16'd1);
          write_reg(REG_MEMORY_COUNT, 16'h0100);
          write_reg(REG_MEMORY_INTERVAL, 16'd2);
          write_reg(REG_READ_CLEAR_MASK, 16'h3F00);
          write_reg(UNUSED_REG_IDX, 16'h0001);
        end
        7: begin
          write_reg(REG_QUEUE_COUNT, CFG_DATA_W'($urandom_range(0, 65535)));
          write_reg(REG_QUEUE_INTERVAL, CFG_DATA_W'($urandom_range(0, 40)));
          write_reg(REG_MEMORY_COUNT, CFG_DATA_W'($urandom_range(0, 65535)));
          write_reg(REG_MEMORY_INTERVAL, CFG_DATA_W'($urandom_range(0, 40)));
          write_reg(REG_READ_CLEAR_MASK, CFG_DATA_W'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(REG_QUEUE_COUNT,
                    {8'($urandom_range(0, 255)), 8'($urandom_range(1, 6))} & 16'hFF07);
          write_reg(REG_QUEUE_INTERVAL, CFG_DATA_W'($urandom_range(0, 12)));
          write_reg(REG_MEMORY_COUNT, CFG_DATA_W'($urandom_range(1, 6)));
          write_reg(REG_MEMORY_INTERVAL, CFG_DATA_W'($urandom_range(0, 12)));
          write_reg(REG_READ_CLEAR_MASK, CFG_DATA_W'($urandom_range(0, 65535)));
        end
      endcase

      // random commands, biased toward the throttled sources
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) op = CMD_REPORT;
        else if (roll < 80) op = CMD_TICK;
        else if (roll < 95) op = CMD_READ;
        else op = CMD_NOP;
        if ($urandom_range(0, 1) == 1)
          code = CODE_W'($urandom_range(EC_QUEUE, EC_MEM));
        else
          code = CODE_W'($urandom_range(0, 15));
        push_cmd(op, code);
        // in phase 4 only, the sender waits for the pipe to empty once mid-phase
        if (phase == 4 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (SETTLE * 2) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/eslt_pkg.sv
hdl/error_status_log_throttle_unit.sv
test/tb_error_status_log_throttle_unit.sv
